### rtl/agdfs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the adjacency graph depth-first search block.
// No dependencies; every other file refers to this package by scoped names.
package agdfs_pkg;

	localparam int VTX_N = 32;              // vertices held in the matrix
	localparam int IDX_W = 5;               // bits of a vertex index
	localparam int LVL_W = 6;               // bits of the walk depth, holds VTX_N
	localparam int CNT_W = 6;               // bits of the vertex count register

	typedef logic [IDX_W-1:0] vtx_t;
	typedef logic [VTX_N-1:0] row_t;
	typedef logic [LVL_W-1:0] lvl_t;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Update request for the adjacency matrix: one symmetric pair per beat.
	typedef struct packed {
		logic en;
		logic set;
		vtx_t a;
		vtx_t b;
	} adj_wr_t;

endpackage

### rtl/adjacency_graph_dfs_component.sv
`timescale 1ns / 1ps
// Top level of the adjacency graph depth-first search block.
// Depends on agdfs_pkg, agdfs_adj and agdfs_scan.
//
// Add and remove edge write the matrix at the next clock edge, and busy never
// rises for them. A query from an in-range start holds busy until the walk has
// left its start: each walk step is one pass through the shared scan unit
// (row read, mask, lowest-bit search) that either descends or backs up one
// level. Results come one per strobe, each one cycle wide, with no way to
// hold them off; the final beat of a query carries last. An out-of-range
// start gives a single beat with error and last set in the cycle after start.
module adjacency_graph_dfs_component (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   command,
	input  logic [4:0]                   first_node,
	input  logic [4:0]                   second_node,
	input  logic                         cfg_wr_en,
	input  logic [agdfs_pkg::CNT_W-1:0]  cfg_wr_data,
	output logic                         strobe,
	output logic [4:0]                   vertex,
	output logic                         last,
	output logic                         error
);

	agdfs_pkg::state_t state_q, state_d;
	logic [agdfs_pkg::CNT_W-1:0] vc_q;
	logic [agdfs_pkg::CNT_W-1:0] n_eff;
	agdfs_pkg::row_t scan_mask;
	agdfs_pkg::row_t visited_q;
	agdfs_pkg::row_t adj_row;
	agdfs_pkg::lvl_t level_q;
	agdfs_pkg::lvl_t lvl_m1, lvl_m2;
	agdfs_pkg::vtx_t top_q, pend_q, scan_idx;
	agdfs_pkg::vtx_t stack_q [agdfs_pkg::VTX_N];
	agdfs_pkg::adj_wr_t adj_wr;
	logic scan_found;
	logic accept, a_ok, b_ok;
	logic q_start, q_err, push, pop, pop_end;
	logic strobe_q, last_q, error_q;
	agdfs_pkg::vtx_t vertex_q;

	assign accept = start && !busy;
	assign n_eff  = (vc_q > agdfs_pkg::CNT_W'(agdfs_pkg::VTX_N)) ?
		agdfs_pkg::CNT_W'(agdfs_pkg::VTX_N) : vc_q;
	assign a_ok   = {1'b0, first_node} < n_eff;
	assign b_ok   = {1'b0, second_node} < n_eff;
	assign lvl_m1 = level_q - agdfs_pkg::LVL_W'(1);
	assign lvl_m2 = level_q - agdfs_pkg::LVL_W'(2);

	always_comb begin
		for (int i = 0; i < agdfs_pkg::VTX_N; i++) begin
			scan_mask[i] = agdfs_pkg::CNT_W'(i) < n_eff;
		end
	end

	always_comb begin
		adj_wr.en  = accept && a_ok && b_ok &&
			(command == agdfs_pkg::CMD_ADD || command == agdfs_pkg::CMD_REMOVE);
		adj_wr.set = command == agdfs_pkg::CMD_ADD;
		adj_wr.a   = first_node;
		adj_wr.b   = second_node;
	end

	agdfs_adj u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (adj_wr),
		.rd_addr (top_q),
		.rd_row  (adj_row)
	);

	agdfs_scan u_scan (
		.row       (adj_row),
		.visited   (visited_q),
		.scan_mask (scan_mask),
		.found     (scan_found),
		.index     (scan_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			agdfs_pkg::ST_IDLE: begin
				if (q_start) state_d = agdfs_pkg::ST_WALK;
			end
			agdfs_pkg::ST_WALK: begin
				if (pop_end) state_d = agdfs_pkg::ST_IDLE;
			end
			default: state_d = agdfs_pkg::ST_IDLE;
		endcase
	end

	// sequencer controls
	always_comb begin
		busy    = 1'b0;
		q_start = 1'b0;
		q_err   = 1'b0;
		push    = 1'b0;
		pop     = 1'b0;
		pop_end = 1'b0;
		case (state_q)
			agdfs_pkg::ST_IDLE: begin
				q_start = accept && command == agdfs_pkg::CMD_QUERY && a_ok;
				q_err   = accept && command == agdfs_pkg::CMD_QUERY && !a_ok;
			end
			agdfs_pkg::ST_WALK: begin
				busy    = 1'b1;
				push    = scan_found && level_q < agdfs_pkg::LVL_W'(agdfs_pkg::VTX_N);
				pop     = !push && level_q != agdfs_pkg::LVL_W'(1);
				pop_end = !push && level_q == agdfs_pkg::LVL_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= agdfs_pkg::ST_IDLE;
			vc_q      <= agdfs_pkg::CNT_W'(agdfs_pkg::VTX_N);
			level_q   <= '0;
			visited_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= q_err || push || pop_end;
			if (cfg_wr_en) vc_q <= cfg_wr_data;
			if (q_start) begin
				level_q   <= agdfs_pkg::LVL_W'(1);
				visited_q <= agdfs_pkg::row_t'(1) << first_node;
			end else if (push) begin
				level_q   <= level_q + agdfs_pkg::LVL_W'(1);
				visited_q <= visited_q | (agdfs_pkg::row_t'(1) << scan_idx);
			end else if (pop || pop_end) begin
				level_q <= lvl_m1;
			end
		end
	end

	// walk payload: the top vertex lives in top_q, those below it on the stack
	always_ff @(posedge clk) begin
		if (q_start) begin
			top_q  <= first_node;
			pend_q <= first_node;
		end else if (push) begin
			stack_q[lvl_m1[agdfs_pkg::IDX_W-1:0]] <= top_q;
			top_q  <= scan_idx;
			pend_q <= scan_idx;
		end else if (pop) begin
			top_q <= stack_q[lvl_m2[agdfs_pkg::IDX_W-1:0]];
		end
		// hold back one vertex so the final beat can carry last
		vertex_q <= q_err ? '0 : pend_q;
		last_q   <= q_err || pop_end;
		error_q  <= q_err;
	end

	assign strobe = strobe_q;
	assign vertex = vertex_q;
	assign last   = last_q;
	assign error  = error_q;

endmodule

### rtl/agdfs_adj.sv
`timescale 1ns / 1ps
// Symmetric adjacency bit matrix, cleared at reset, with one row read port.
// Depends on agdfs_pkg.
module agdfs_adj (
	input  logic              clk,
	input  logic              arst_n,
	input  agdfs_pkg::adj_wr_t wr,
	input  agdfs_pkg::vtx_t    rd_addr,
	output agdfs_pkg::row_t    rd_row
);

	agdfs_pkg::row_t rows_q [agdfs_pkg::VTX_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < agdfs_pkg::VTX_N; i++) begin
				rows_q[i] <= '0;
			end
		end else if (wr.en) begin
			// a self loop lands on the same bit twice, which is harmless
			for (int i = 0; i < agdfs_pkg::VTX_N; i++) begin
				if (agdfs_pkg::vtx_t'(i) == wr.a) begin
					rows_q[i][wr.b] <= wr.set;
				end
				if (agdfs_pkg::vtx_t'(i) == wr.b) begin
					rows_q[i][wr.a] <= wr.set;
				end
			end
		end
	end

	assign rd_row = rows_q[rd_addr];

endmodule

### rtl/agdfs_scan.sv
`timescale 1ns / 1ps
// Shared scan unit: lowest unvisited in-range neighbour of one row.
// Depends on agdfs_pkg.
module agdfs_scan (
	input  agdfs_pkg::row_t row,
	input  agdfs_pkg::row_t visited,
	input  agdfs_pkg::row_t scan_mask,
	output logic            found,
	output agdfs_pkg::vtx_t index
);

	agdfs_pkg::row_t cand;

	assign cand  = row & scan_mask & ~visited;
	assign found = |cand;

	always_comb begin
		index = '0;
		for (int i = agdfs_pkg::VTX_N - 1; i >= 0; i--) begin
			if (cand[i]) begin
				index = agdfs_pkg::vtx_t'(i);
			end
		end
	end

endmodule
